@@ hdl/ssfl_pkg.sv @@
// Shared types, constants and helpers for the substring search block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ssfl_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 12;
    localparam int PAT_W  = 64;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    localparam logic [BYTE_W-1:0] LOWER_A     = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_Z     = 8'h7A;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;
    localparam logic [BYTE_W-1:0] END_BYTE    = 8'h00;

    // register index, taken from the address above the 8-byte offset
    typedef enum logic [1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_IGNORE_CASE    = 2'd2,
        REG_FIND_LAST      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              last_byte;
    } t_in;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
    } t_out;

    typedef struct packed {
        logic [PAT_W-1:0] pattern_bytes;
        logic [LEN_W-1:0] pattern_length;
        logic             ignore_case;
        logic             find_last;
    } t_cfg;

    // map a-z to A-Z when folding is on
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                    input logic en);
        logic [BYTE_W-1:0] r;
        r = b;
        if (en && (b inside {[LOWER_A:LOWER_Z]})) begin
            r = b - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/ssfl_regs.sv @@
// APB-style configuration registers of the substring search block.
// Depends on ssfl_pkg for the register indexes and the config struct.
`timescale 1ns / 1ps
`default_nettype none

module ssfl_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ssfl_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ssfl_pkg::DATA_W-1:0] pwdata,
    output logic      [ssfl_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output ssfl_pkg::t_cfg                  o_cfg
);

    ssfl_pkg::t_cfg     r_cfg;
    ssfl_pkg::t_reg_idx idx;
    logic               wr;

    assign idx    = ssfl_pkg::t_reg_idx'(paddr[4:3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            case (idx)
                ssfl_pkg::REG_PATTERN_BYTES:  r_cfg.pattern_bytes  <= pwdata;
                ssfl_pkg::REG_PATTERN_LENGTH: r_cfg.pattern_length <=
                                                  pwdata[ssfl_pkg::LEN_W-1:0];
                ssfl_pkg::REG_IGNORE_CASE:    r_cfg.ignore_case    <= pwdata[0];
                ssfl_pkg::REG_FIND_LAST:      r_cfg.find_last      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (idx)
            ssfl_pkg::REG_PATTERN_BYTES:  prdata = r_cfg.pattern_bytes;
            ssfl_pkg::REG_PATTERN_LENGTH: prdata =
                ssfl_pkg::DATA_W'(r_cfg.pattern_length);
            ssfl_pkg::REG_IGNORE_CASE:    prdata = ssfl_pkg::DATA_W'(r_cfg.ignore_case);
            ssfl_pkg::REG_FIND_LAST:      prdata = ssfl_pkg::DATA_W'(r_cfg.find_last);
            default:                      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/ssfl_match.sv @@
// Parallel pattern comparators against the tail of the byte window.
// Depends on ssfl_pkg for the config struct and case folding.
`timescale 1ns / 1ps
`default_nettype none

module ssfl_match #(
    parameter int MAX_PATTERN = 8,
    parameter int CNT_W       = 12
) (
    input  wire logic [8*MAX_PATTERN-1:0]    i_window,
    input  wire logic [CNT_W-1:0]            i_count,
    input  wire ssfl_pkg::t_cfg              i_cfg,
    output logic                             o_hit,
    output logic      [ssfl_pkg::POS_W-1:0]  o_start
);

    localparam int LW = ssfl_pkg::LEN_W;
    localparam int SW = (CNT_W > ssfl_pkg::POS_W) ? CNT_W : ssfl_pkg::POS_W;

    logic [SW-1:0] cnt_x;
    logic [SW-1:0] len_x;
    logic [SW-1:0] diff;
    logic          enough;

    assign cnt_x   = SW'(i_count);
    assign len_x   = SW'(i_cfg.pattern_length);
    assign enough  = cnt_x >= len_x;
    assign diff    = cnt_x - len_x;
    assign o_start = diff[ssfl_pkg::POS_W-1:0];

    // one comparator set per candidate length, pick by the configured length
    always_comb begin
        logic m;
        o_hit = 1'b0;
        for (int l = 1; l <= MAX_PATTERN; l++) begin
            m = 1'b1;
            for (int i = 0; i < l; i++) begin
                if (ssfl_pkg::fold_byte(i_cfg.pattern_bytes[8*i +: 8], i_cfg.ignore_case)
                    != ssfl_pkg::fold_byte(i_window[8*(l-1-i) +: 8], i_cfg.ignore_case)) begin
                    m = 1'b0;
                end
            end
            if (i_cfg.pattern_length == LW'(l)) begin
                o_hit = m;
            end
        end
        if (!enough) begin
            o_hit = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ssfl_core.sv @@
// Text state of the substring search: window, count and match positions.
// Depends on ssfl_pkg and instantiates ssfl_match.
`timescale 1ns / 1ps
`default_nettype none

module ssfl_core #(
    parameter int MAX_TEXT    = 4096,
    parameter int MAX_PATTERN = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire ssfl_pkg::t_in  i_word,
    input  wire ssfl_pkg::t_cfg i_cfg,
    output ssfl_pkg::t_out o_res
);

    localparam int CNT_W = $clog2(MAX_TEXT);
    localparam int WIN_W = 8 * MAX_PATTERN;
    localparam int PW    = ssfl_pkg::POS_W;

    logic [WIN_W-1:0] r_win,   n_win;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic [PW-1:0]    r_first, n_first;
    logic [PW-1:0]    r_last,  n_last;
    logic             r_any,   n_any;
    logic             r_ended, n_ended;

    logic [WIN_W-1:0] win_sh;
    logic [CNT_W-1:0] cnt_inc;
    logic             take;
    logic             hit;
    logic             new_match;
    logic [PW-1:0]    start;
    logic [PW-1:0]    pos;

    // shifted window and count as they stand after this byte
    generate
        if (MAX_PATTERN > 1) begin : g_shift
            assign win_sh = {r_win[WIN_W-9:0], i_word.text_byte};
        end else begin : g_one
            assign win_sh = i_word.text_byte;
        end
    endgenerate
    assign cnt_inc = r_cnt + CNT_W'(1);

    // a byte counts only before the end byte and below the length limit
    assign take = !r_ended && (i_word.text_byte != ssfl_pkg::END_BYTE)
                  && (r_cnt < CNT_W'(MAX_TEXT - 1));

    ssfl_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .CNT_W       (CNT_W)
    ) u_match (
        .i_window (win_sh),
        .i_count  (cnt_inc),
        .i_cfg    (i_cfg),
        .o_hit    (hit),
        .o_start  (start)
    );

    assign new_match = take && hit;

    // next text state
    always_comb begin
        n_win   = take ? win_sh  : r_win;
        n_cnt   = take ? cnt_inc : r_cnt;
        n_any   = r_any || new_match;
        n_first = (new_match && !r_any) ? start : r_first;
        n_last  = new_match ? start : r_last;
        n_ended = r_ended || (i_word.text_byte == ssfl_pkg::END_BYTE);
    end

    // result as it would leave on a last word
    assign pos   = i_cfg.find_last ? n_last : n_first;
    assign o_res = '{found: n_any, match_position: (n_any ? pos : '0)};

    // advance on each step, clear after the last word of a text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_cnt   <= '0;
            r_first <= '0;
            r_last  <= '0;
            r_any   <= 1'b0;
            r_ended <= 1'b0;
        end else if (i_step) begin
            if (i_word.last_byte) begin
                r_win   <= '0;
                r_cnt   <= '0;
                r_first <= '0;
                r_last  <= '0;
                r_any   <= 1'b0;
                r_ended <= 1'b0;
            end else begin
                r_win   <= n_win;
                r_cnt   <= n_cnt;
                r_first <= n_first;
                r_last  <= n_last;
                r_any   <= n_any;
                r_ended <= n_ended;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/substring_search_first_last.sv @@
// Streaming substring search reporting the first or last match start per text.
// One word per cycle unless a held result stalls a last word; an input register
// and a result register bound the single compare stage. The result is loaded
// when the word flagged last steps, later while a stalled result holds it back.
// Reset (synchronous, active low) clears the text state, the config registers
// and both valid flags. Depends on ssfl_pkg, ssfl_regs, ssfl_core.
`timescale 1ns / 1ps
`default_nettype none

module substring_search_first_last #(
    parameter int MAX_TEXT    = 4096,
    parameter int MAX_PATTERN = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire ssfl_pkg::t_in               i_in_word,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output ssfl_pkg::t_out                   o_out_word,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ssfl_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ssfl_pkg::DATA_W-1:0] pwdata,
    output logic      [ssfl_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    ssfl_pkg::t_cfg cfg;
    ssfl_pkg::t_in  r_in;
    logic           r_in_vld;
    ssfl_pkg::t_out r_out;
    logic           r_out_vld;
    ssfl_pkg::t_out res;
    logic           out_free;
    logic           step;
    logic           in_take;

    ssfl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ssfl_core #(
        .MAX_TEXT    (MAX_TEXT),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // a word steps unless it is a last word with no room for its result
    assign out_free   = !r_out_vld || !i_out_stall;
    assign step       = r_in_vld && (!r_in.last_byte || out_free);
    assign o_in_stall = r_in_vld && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_word;
        end
    end

    // result register: load on a last word, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step && r_in.last_byte) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.last_byte) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // a missing match always reports position zero
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.found |-> o_out_word.match_position == '0)
        else $error("match position set without a match");

    // a last word that steps shows its result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in.last_byte |=> o_out_valid)
        else $error("result missing after last word");

    // never overwrite a held result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_out_stall && step |-> !r_in.last_byte)
        else $error("held result overwritten");

    // an empty input register never stalls the sender
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> !o_in_stall)
        else $error("stall with empty input register");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for substring_search_first_last: directed table, then random
// phases, each under its own register setting, checked against a predictor.
// Depends on ssfl_pkg and the substring_search_first_last RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int  MAX_TEXT    = 4096;
    localparam int  MAX_PATTERN = 8;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  SETTLE      = 4;
    localparam int  PHASES      = 14;
    localparam int  PHASE_WORDS = 135;
    localparam int  DIR_ROWS    = 23;
    localparam logic [7:0] NUL  = 8'h00;
    // text alphabet: a b A B z Z and the neighbors of both letter ranges
    localparam logic [79:0] ALPHABET = {8'h61, 8'h62, 8'h41, 8'h42, 8'h7A,
                                        8'h5A, 8'h60, 8'h7B, 8'h40, 8'h5B};

    typedef enum logic [1:0] {
        SET_RESET,
        SET_FOLD_FIRST,
        SET_ONES_LAST
    } t_preset;

    typedef struct packed {
        t_preset     preset;
        logic [7:0]  text_byte;
        logic        last_byte;
        logic        typed;
        logic        found;
        logic [11:0] position;
    } t_dir_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    ssfl_pkg::t_in                     i_in_word;
    logic                              o_out_valid;
    logic                              i_out_stall;
    ssfl_pkg::t_out                    o_out_word;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [ssfl_pkg::ADDR_W-1:0]       paddr;
    logic [ssfl_pkg::DATA_W-1:0]       pwdata;
    logic [ssfl_pkg::DATA_W-1:0]       prdata;
    logic                              pready;

    // register copies seen by the predictor
    logic [63:0] cfg_pattern;
    logic [3:0]  cfg_length;
    logic        cfg_fold;
    logic        cfg_report_last;

    // text state of the predictor
    logic [63:0] search_window;
    int          bytes_seen;
    logic [11:0] first_start;
    logic [11:0] latest_start;
    logic        seen_match;
    logic        text_done;

    ssfl_pkg::t_out pending_results[$];
    ssfl_pkg::t_out head_result;

    bit  idle_on;
    int  gap_left;
    int  stall_left;
    int  error_count;
    int  cycle_count;
    int  words_sent;
    int  results_seen;
    int  matches_seen;
    int  settings_used;

    t_dir_row directed_rows [DIR_ROWS] = '{
        // reset registers: empty pattern never matches, zero byte alone is an empty text
        '{SET_RESET,      8'h41, 1'b1, 1'b1, 1'b0, 12'd0},
        '{SET_RESET,      8'h00, 1'b1, 1'b1, 1'b0, 12'd0},
        // pattern "aB" folded, first match
        '{SET_FOLD_FIRST, 8'h78, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_FOLD_FIRST, 8'h41, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_FOLD_FIRST, 8'h62, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_FOLD_FIRST, 8'h41, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_FOLD_FIRST, 8'h42, 1'b1, 1'b0, 1'b0, 12'd0},
        '{SET_FOLD_FIRST, 8'h00, 1'b1, 1'b1, 1'b0, 12'd0},
        // zero byte ends the text, the flagged byte after it is ignored
        '{SET_FOLD_FIRST, 8'h41, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_FOLD_FIRST, 8'h00, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_FOLD_FIRST, 8'h42, 1'b1, 1'b1, 1'b0, 12'd0},
        '{SET_FOLD_FIRST, 8'hFF, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_FOLD_FIRST, 8'h61, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_FOLD_FIRST, 8'h42, 1'b1, 1'b0, 1'b0, 12'd0},
        // all-ones pattern of full length, last match
        '{SET_ONES_LAST,  8'hFF, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_ONES_LAST,  8'hFF, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_ONES_LAST,  8'hFF, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_ONES_LAST,  8'hFF, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_ONES_LAST,  8'hFF, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_ONES_LAST,  8'hFF, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_ONES_LAST,  8'hFF, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_ONES_LAST,  8'hFF, 1'b0, 1'b0, 1'b0, 12'd0},
        '{SET_ONES_LAST,  8'hFF, 1'b1, 1'b1, 1'b1, 12'd1}
    };

    substring_search_first_last #(
        .MAX_TEXT    (MAX_TEXT),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ASCII upper-casing when folding is enabled
    function automatic logic [7:0] upcase(input logic [7:0] b);
        if (cfg_fold && b >= 8'h61 && b <= 8'h7A) begin
            return b - 8'h20;
        end
        return b;
    endfunction

    // compare the pattern against the newest bytes of the window
    function automatic bit tail_hit();
        int len;
        len = int'(cfg_length);
        if (len == 0 || len > MAX_PATTERN || bytes_seen < len) begin
            return 1'b0;
        end
        for (int i = 0; i < len; i++) begin
            if (upcase(cfg_pattern[8*i +: 8]) != upcase(search_window[8*(len-1-i) +: 8])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // advance the text state by one word; returns 1 when the word yields a result
    function automatic bit absorb_word(input ssfl_pkg::t_in w, output ssfl_pkg::t_out res);
        logic [11:0] start;
        res = '0;
        if (!text_done) begin
            if (w.text_byte == NUL) begin
                text_done = 1'b1;
            end else if (bytes_seen < MAX_TEXT - 1) begin
                search_window = {search_window[55:0], w.text_byte};
                bytes_seen++;
                if (tail_hit()) begin
                    start = 12'(bytes_seen - int'(cfg_length));
                    if (!seen_match) begin
                        first_start = start;
                    end
                    latest_start = start;
                    seen_match   = 1'b1;
                end
            end
        end
        if (!w.last_byte) begin
            return 1'b0;
        end
        res.found          = seen_match;
        res.match_position = !seen_match ? 12'd0 : (cfg_report_last ? latest_start : first_start);
        search_window = '0;
        bytes_seen    = 0;
        first_start   = '0;
        latest_start  = '0;
        seen_match    = 1'b0;
        text_done     = 1'b0;
        return 1'b1;
    endfunction

    // randomly flip the case of a letter
    function automatic logic [7:0] shuffle_case(input logic [7:0] b);
        if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) && $urandom_range(0, 1)) begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    // drive one word from a falling edge, hold it until taken, predict its result
    task automatic push_word(input logic [7:0] text_byte, input logic last_byte,
                             input bit typed, input ssfl_pkg::t_out typed_res);
        ssfl_pkg::t_out res;
        if (idle_on && gap_left == 0 && $urandom_range(0, 15) == 0) begin
            gap_left = $urandom_range(1, 16);
        end
        while (gap_left > 0) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
            gap_left--;
        end
        i_in_valid = 1'b1;
        i_in_word  = '{text_byte: text_byte, last_byte: last_byte};
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        words_sent++;
        if (absorb_word(i_in_word, res)) begin
            pending_results.push_back(typed ? typed_res : res);
        end
        @(negedge i_clk);
    endtask

    // wait for all results, then let the pipeline settle
    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // one register write: setup phase, then access until pready
    task automatic write_reg(input ssfl_pkg::t_reg_idx idx, input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        case (idx)
            ssfl_pkg::REG_PATTERN_BYTES:  cfg_pattern     = value;
            ssfl_pkg::REG_PATTERN_LENGTH: cfg_length      = value[3:0];
            ssfl_pkg::REG_IGNORE_CASE:    cfg_fold        = value[0];
            ssfl_pkg::REG_FIND_LAST:      cfg_report_last = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic [63:0] pattern, input logic [3:0] length,
                              input logic fold, input logic report_last);
        drain();
        write_reg(ssfl_pkg::REG_PATTERN_BYTES, pattern);
        write_reg(ssfl_pkg::REG_PATTERN_LENGTH, 64'(length));
        write_reg(ssfl_pkg::REG_IGNORE_CASE, 64'(fold));
        write_reg(ssfl_pkg::REG_FIND_LAST, 64'(report_last));
        settings_used++;
    endtask

    task automatic apply_preset(input t_preset preset);
        case (preset)
            SET_FOLD_FIRST: set_config(64'h4261, 4'd2, 1'b1, 1'b0);
            SET_ONES_LAST:  set_config('1, 4'd8, 1'b0, 1'b1);
            default:        set_config('0, 4'd0, 1'b0, 1'b0);
        endcase
    endtask

    // build one text from pattern copies, alphabet letters, random bytes and rare zeros
    task automatic send_text(input int length, output int sent);
        logic [7:0] text_q[$];
        int         pick;
        while (text_q.size() < length) begin
            pick = $urandom_range(0, 99);
            if (pick < 22 && cfg_length != 0 && cfg_length <= MAX_PATTERN) begin
                for (int i = 0; i < int'(cfg_length); i++) begin
                    text_q.push_back(shuffle_case(cfg_pattern[8*i +: 8]));
                end
            end else if (pick < 24) begin
                text_q.push_back(NUL);
            end else if (pick < 36) begin
                text_q.push_back(8'($urandom_range(1, 255)));
            end else begin
                text_q.push_back(shuffle_case(ALPHABET[8*$urandom_range(0, 9) +: 8]));
            end
        end
        foreach (text_q[i]) begin
            push_word(text_q[i], i == text_q.size() - 1, 1'b0, '0);
        end
        sent = text_q.size();
    endtask

    // random pattern: alphabet bytes around the fold boundaries, or fully random bits
    function automatic logic [63:0] make_pattern();
        logic [63:0] pat;
        if ($urandom_range(0, 3) == 0) begin
            pat = {$urandom, $urandom};
        end else begin
            for (int i = 0; i < 8; i++) begin
                pat[8*i +: 8] = shuffle_case(ALPHABET[8*$urandom_range(0, 9) +: 8]);
            end
        end
        return pat;
    endfunction

    // output side: random stall bursts, no new burst once idling is switched off
    initial begin
        i_out_stall = 1'b0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                i_out_stall = 1'b1;
                stall_left  = $urandom_range(1, 16) - 1;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // check each taken result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: found=%0d match_position=%0d",
                       o_out_word.found, o_out_word.match_position);
                error_count++;
            end else begin
                head_result = pending_results.pop_front();
                if (o_out_word.found) begin
                    matches_seen++;
                end
                if (o_out_word.found !== head_result.found) begin
                    $error("found: expected %0d, got %0d", head_result.found, o_out_word.found);
                    error_count++;
                end
                if (o_out_word.match_position !== head_result.match_position) begin
                    $error("match_position: expected %0d, got %0d",
                           head_result.match_position, o_out_word.match_position);
                    error_count++;
                end
            end
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[substring_search_first_last] ERROR");
            $finish;
        end
    end

    initial begin
        t_preset        active;
        ssfl_pkg::t_out typed_res;
        logic [3:0]     length;
        logic [63:0]    pattern;
        logic           fold;
        logic           report_last;
        int             phase_words;
        int             sent;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_on     = 1'b1;
        gap_left    = 0;
        error_count = 0;
        cycle_count = 0;
        words_sent  = 0;
        results_seen  = 0;
        matches_seen  = 0;
        settings_used = 0;
        cfg_pattern     = '0;
        cfg_length      = '0;
        cfg_fold        = 1'b0;
        cfg_report_last = 1'b0;
        search_window = '0;
        bytes_seen    = 0;
        first_start   = '0;
        latest_start  = '0;
        seen_match    = 1'b0;
        text_done     = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // walk the directed table, switching presets where a row asks for one
        active = SET_RESET;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].preset != active) begin
                active = directed_rows[i].preset;
                apply_preset(active);
            end
            typed_res = '{found: directed_rows[i].found,
                          match_position: directed_rows[i].position};
            push_word(directed_rows[i].text_byte, directed_rows[i].last_byte,
                      directed_rows[i].typed, typed_res);
        end

        // random phases; the first ones pin the register extremes
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       length = 4'd1;
                1:       length = 4'd8;
                2:       length = 4'd0;
                3:       length = 4'd15;
                4:       length = 4'd9;
                default: length = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(1, 8))
                                                             : 4'($urandom_range(0, 15));
            endcase
            if (ph == 5) begin
                pattern = '1;
            end else if (ph == 6) begin
                pattern = '0;
            end else begin
                pattern = make_pattern();
            end
            fold        = (ph < 4) ? ph[0] : 1'($urandom_range(0, 1));
            report_last = (ph < 4) ? ph[1] : 1'($urandom_range(0, 1));
            set_config(pattern, length, fold, report_last);
            idle_on = (ph != PHASES - 1);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                send_text(($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 24), sent);
                phase_words += sent;
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end

        $display("sent %0d text words under %0d register settings", words_sent, settings_used);
        $display("checked %0d results, %0d of them with a match", results_seen, matches_seen);
        if (error_count == 0) begin
            $display("[substring_search_first_last] OK");
        end else begin
            $display("[substring_search_first_last] ERROR");
        end
        $finish;
    end

endmodule
